// ===== rtl/bpgd_pkg.sv =====
// ============================================================================
// bpgd_pkg: shared types and constants of the beat peak and gap detector
// Field widths, register reset values, register indexes, controller states
// and the command and status bundles between controller and datapath.
// ============================================================================
package bpgd_pkg;

    localparam int LEVEL_W     = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int POWER_W     = 24;
    localparam int THR_W       = 25;
    localparam int SILENT_W    = 17;
    localparam int SINCE_W     = 16;

    localparam int HISTORY_DEPTH_DEF = 32;

    // Defaults for 30 frames per second: 3 s, 8 s, and 60 s at 200 beats/min
    localparam logic [CFG_W-1:0] GAP_LENGTH_RST      = 16'd90;
    localparam logic [CFG_W-1:0] LONG_GAP_LENGTH_RST = 16'd240;
    localparam logic [CFG_W-1:0] PEAK_SPACING_RST    = 16'd9;

    localparam logic [POWER_W-1:0]  POWER_MAX  = '1;
    localparam logic [SILENT_W-1:0] SILENT_MAX = '1;
    localparam logic [SINCE_W-1:0]  SINCE_MAX  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_LENGTH      = 2'd0,
        CFG_LONG_GAP_LENGTH = 2'd1,
        CFG_PEAK_SPACING    = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WRITE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_BEAT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accum;         // add a non-final pair to the frame sum
        logic frame_end;     // close the frame, update gap tracking
        logic clear_result;  // gap frame: zero beat, average and threshold
        logic hist_step;     // advance write slot, read the entry it replaces
        logic hist_write;    // store frame power, update the running total
        logic div_start;     // start the averaging division
        logic beat_eval;     // threshold compare and spacing check
        logic out_load;      // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic gap;           // gap flag after the frame update
        logic div_done;      // last divider step this cycle
        logic out_free;      // output register can take a result
    } status_t;

endpackage

// ===== rtl/bpgd_in_if.sv =====
// ============================================================================
// bpgd_in_if: input channel of the beat peak and gap detector
// One left/right channel pair per transfer, final pair of a frame marked.
// ============================================================================
interface bpgd_in_if;

    logic                         valid;
    logic                         ready;
    logic [bpgd_pkg::LEVEL_W-1:0] left_level;
    logic [bpgd_pkg::LEVEL_W-1:0] right_level;
    logic                         last_channel;

    modport source (
        output valid,
        input  ready,
        output left_level,
        output right_level,
        output last_channel
    );

    modport sink (
        input  valid,
        output ready,
        input  left_level,
        input  right_level,
        input  last_channel
    );

endinterface

// ===== rtl/bpgd_out_if.sv =====
// ============================================================================
// bpgd_out_if: result channel of the beat peak and gap detector
// One result per frame: beat and gap flags, frame power, average, threshold.
// ============================================================================
interface bpgd_out_if;

    logic                         valid;
    logic                         ready;
    logic                         beat;
    logic                         in_gap;
    logic                         in_long_gap;
    logic                         gap_ended;
    logic [bpgd_pkg::POWER_W-1:0] frame_power;
    logic [bpgd_pkg::POWER_W-1:0] average_power;
    logic [bpgd_pkg::THR_W-1:0]   threshold;

    modport source (
        output valid,
        input  ready,
        output beat,
        output in_gap,
        output in_long_gap,
        output gap_ended,
        output frame_power,
        output average_power,
        output threshold
    );

    modport sink (
        input  valid,
        output ready,
        input  beat,
        input  in_gap,
        input  in_long_gap,
        input  gap_ended,
        input  frame_power,
        input  average_power,
        input  threshold
    );

endinterface

// ===== rtl/bpgd_div.sv =====
// ============================================================================
// bpgd_div: serial restoring divider
// One quotient bit per cycle while busy; done is high during the final step.
// ============================================================================
module bpgd_div #(
    parameter int DVD_W = 29,
    parameter int DVS_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DVD_W-1:0] work_reg;
    logic [DVD_W-1:0] work_next;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial    = {rem_reg, work_reg[DVD_W-1]};
    assign fits     = trial >= {1'b0, divisor};
    assign done     = busy_reg && (cnt_reg == CNT_W'(DVD_W - 1));
    assign quotient = work_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit in, subtract where the divisor fits
            rem_next  = fits ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
            work_next = {work_reg[DVD_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

endmodule

// ===== rtl/bpgd_ctrl.sv =====
// ============================================================================
// bpgd_ctrl: frame sequencer of the beat peak and gap detector
// Takes channel pairs, and on the final pair walks the datapath through gap
// update, then outside a gap history update, division and beat decision, and result hand-off.
// ============================================================================
module bpgd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    input  bpgd_pkg::status_t status,
    output bpgd_pkg::cmd_t    cmd
);

    bpgd_pkg::state_t state_reg;
    bpgd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpgd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            bpgd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_last)
                    begin
                        cmd.frame_end = 1'b1;
                        state_next    = bpgd_pkg::ST_CHECK;
                    end
                    else
                    begin
                        cmd.accum = 1'b1;
                    end
                end
            end
            bpgd_pkg::ST_CHECK:
            begin
                // during a gap the history is left alone
                if (status.gap)
                begin
                    cmd.clear_result = 1'b1;
                    state_next       = bpgd_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.hist_step = 1'b1;
                    state_next    = bpgd_pkg::ST_WRITE;
                end
            end
            bpgd_pkg::ST_WRITE:
            begin
                cmd.hist_write = 1'b1;
                state_next     = bpgd_pkg::ST_DIV_GO;
            end
            bpgd_pkg::ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = bpgd_pkg::ST_DIV_WAIT;
            end
            bpgd_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = bpgd_pkg::ST_BEAT;
                end
            end
            bpgd_pkg::ST_BEAT:
            begin
                cmd.beat_eval = 1'b1;
                state_next    = bpgd_pkg::ST_EMIT;
            end
            bpgd_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = bpgd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpgd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bpgd_dp.sv =====
// ============================================================================
// bpgd_dp: datapath of the beat peak and gap detector
// Frame sum, silence tracking, power history ring with running total,
// averaging divider, beat decision, configuration and output register.
// ============================================================================
module bpgd_dp #(
    parameter int HISTORY_DEPTH = bpgd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bpgd_pkg::cmd_t                 cmd,
    output bpgd_pkg::status_t              status,
    input  logic                           cfg_we,
    input  logic [bpgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpgd_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [bpgd_pkg::LEVEL_W-1:0]   left_level,
    input  logic [bpgd_pkg::LEVEL_W-1:0]   right_level,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic                           beat,
    output logic                           in_gap,
    output logic                           in_long_gap,
    output logic                           gap_ended,
    output logic [bpgd_pkg::POWER_W-1:0]   frame_power,
    output logic [bpgd_pkg::POWER_W-1:0]   average_power,
    output logic [bpgd_pkg::THR_W-1:0]     threshold
);

    localparam int PW  = bpgd_pkg::POWER_W;
    localparam int TW  = bpgd_pkg::THR_W;
    localparam int SCW = bpgd_pkg::SILENT_W;
    localparam int BW  = bpgd_pkg::SINCE_W;
    localparam int SW  = $clog2(HISTORY_DEPTH);
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int HW  = PW + $clog2(HISTORY_DEPTH);

    // configuration
    logic [bpgd_pkg::CFG_W-1:0] gap_len_reg;
    logic [bpgd_pkg::CFG_W-1:0] long_len_reg;
    logic [bpgd_pkg::CFG_W-1:0] spacing_reg;

    // frame and gap state
    logic [PW-1:0]  frame_sum_reg;
    logic           nonzero_reg;
    logic [SCW-1:0] silent_cnt_reg;
    logic           gap_reg;
    logic           long_reg;
    logic           ended_reg;
    logic [PW-1:0]  power_reg;

    // history state
    logic [PW-1:0]  hist_mem [HISTORY_DEPTH];
    logic [PW-1:0]  rd_reg;
    logic [SW-1:0]  slot_reg;
    logic [CW-1:0]  filled_reg;
    logic           full_reg;
    logic [HW-1:0]  total_reg;
    logic [BW-1:0]  since_reg;

    // per-frame result
    logic           beat_reg;
    logic [PW-1:0]  avg_reg;
    logic [TW-1:0]  thr_reg;

    // output register
    logic           out_valid_reg;
    logic           out_beat_reg;
    logic           out_gap_reg;
    logic           out_long_reg;
    logic           out_ended_reg;
    logic [PW-1:0]  out_power_reg;
    logic [PW-1:0]  out_avg_reg;
    logic [TW-1:0]  out_thr_reg;

    logic [PW+1:0]  sum_wide;
    logic           silent;
    logic [SCW-1:0] cnt_inc;
    logic [SCW-1:0] cnt_new;
    logic           gap_hit;
    logic           long_hit;
    logic [SW-1:0]  slot_new;
    logic [HW-1:0]  total_base;
    logic [HW-1:0]  total_drop;
    logic           div_done;
    logic [HW-1:0]  quotient;
    logic [PW-1:0]  avg;
    logic [TW-1:0]  thr;
    logic           beat_raw;
    logic           beat_ok;
    logic [BW-1:0]  since_inc;

    // frame sum and silence
    assign sum_wide = {2'b00, frame_sum_reg} + (PW+2)'(left_level) + (PW+2)'(right_level);
    assign silent   = !nonzero_reg && (left_level == '0) && (right_level == '0);
    assign cnt_inc  = (silent_cnt_reg == bpgd_pkg::SILENT_MAX) ?
                      silent_cnt_reg : silent_cnt_reg + 1'b1;
    assign cnt_new  = silent ? cnt_inc : '0;
    assign gap_hit  = cnt_new > SCW'(gap_len_reg);
    assign long_hit = cnt_new > SCW'(long_len_reg);

    // history ring
    assign slot_new   = ended_reg ? '0 :
                        (slot_reg == SW'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    assign total_base = ended_reg ? '0 : total_reg;
    assign total_drop = full_reg ? HW'(rd_reg) : '0;

    // beat decision
    assign avg       = quotient[PW-1:0];
    assign thr       = TW'(avg) + TW'(avg >> 2) + TW'(avg >> 3);
    assign beat_raw  = ended_reg || (TW'(power_reg) >= thr);
    assign beat_ok   = beat_raw && (since_reg >= spacing_reg);
    assign since_inc = (since_reg == bpgd_pkg::SINCE_MAX) ? since_reg : since_reg + 1'b1;

    assign status.gap      = gap_reg;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    bpgd_div #(
        .DVD_W (HW),
        .DVS_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (total_reg),
        .divisor  (filled_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_len_reg    <= bpgd_pkg::GAP_LENGTH_RST;
            long_len_reg   <= bpgd_pkg::LONG_GAP_LENGTH_RST;
            spacing_reg    <= bpgd_pkg::PEAK_SPACING_RST;
            frame_sum_reg  <= '0;
            nonzero_reg    <= 1'b0;
            silent_cnt_reg <= '0;
            gap_reg        <= 1'b0;
            long_reg       <= 1'b0;
            ended_reg      <= 1'b0;
            slot_reg       <= SW'(HISTORY_DEPTH - 1);
            filled_reg     <= '0;
            full_reg       <= 1'b0;
            total_reg      <= '0;
            since_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bpgd_pkg::CFG_GAP_LENGTH:      gap_len_reg  <= cfg_wdata;
                    bpgd_pkg::CFG_LONG_GAP_LENGTH: long_len_reg <= cfg_wdata;
                    bpgd_pkg::CFG_PEAK_SPACING:    spacing_reg  <= cfg_wdata;
                    default:                       ;
                endcase
            end

            if (cmd.accum)
            begin
                frame_sum_reg <= (sum_wide > (PW+2)'(bpgd_pkg::POWER_MAX)) ?
                                 bpgd_pkg::POWER_MAX : sum_wide[PW-1:0];
                if ((left_level | right_level) != '0)
                begin
                    nonzero_reg <= 1'b1;
                end
            end

            if (cmd.frame_end)
            begin
                frame_sum_reg  <= '0;
                nonzero_reg    <= 1'b0;
                silent_cnt_reg <= cnt_new;
                ended_reg      <= !silent && gap_reg;
                if (silent)
                begin
                    gap_reg  <= gap_reg || gap_hit;
                    long_reg <= long_reg || long_hit;
                end
                else if (gap_reg)
                begin
                    // the long gap flag drops only when a gap ends
                    gap_reg  <= 1'b0;
                    long_reg <= 1'b0;
                end
            end

            if (cmd.hist_step)
            begin
                slot_reg <= slot_new;
                full_reg <= !ended_reg && (filled_reg == CW'(HISTORY_DEPTH));
                if (ended_reg)
                begin
                    filled_reg <= CW'(1);
                    since_reg  <= spacing_reg;
                end
                else if (filled_reg != CW'(HISTORY_DEPTH))
                begin
                    filled_reg <= filled_reg + 1'b1;
                end
            end

            if (cmd.hist_write)
            begin
                total_reg <= total_base - total_drop + HW'(power_reg);
            end

            if (cmd.beat_eval)
            begin
                since_reg <= beat_ok ? BW'(1) : since_inc;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // history memory: read the replaced entry on step, write the new power after
    always_ff @(posedge clk)
    begin
        if (cmd.hist_step)
        begin
            rd_reg <= hist_mem[slot_new];
        end
        if (cmd.hist_write)
        begin
            hist_mem[slot_reg] <= power_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.frame_end)
        begin
            power_reg <= frame_sum_reg;
        end
        if (cmd.clear_result)
        begin
            beat_reg <= 1'b0;
            avg_reg  <= '0;
            thr_reg  <= '0;
        end
        else if (cmd.beat_eval)
        begin
            beat_reg <= beat_ok;
            avg_reg  <= avg;
            thr_reg  <= thr;
        end
        if (cmd.out_load)
        begin
            out_beat_reg  <= beat_reg;
            out_gap_reg   <= gap_reg;
            out_long_reg  <= long_reg;
            out_ended_reg <= ended_reg;
            out_power_reg <= power_reg;
            out_avg_reg   <= avg_reg;
            out_thr_reg   <= thr_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign beat          = out_beat_reg;
    assign in_gap        = out_gap_reg;
    assign in_long_gap   = out_long_reg;
    assign gap_ended     = out_ended_reg;
    assign frame_power   = out_power_reg;
    assign average_power = out_avg_reg;
    assign threshold     = out_thr_reg;

endmodule

// ===== rtl/beat_peak_and_gap_detector_core.sv =====
// ============================================================================
// beat_peak_and_gap_detector_core: beat peak and silence gap detector
// Sums channel levels per frame, tracks silence gaps, keeps a power history
// and flags beats (power reaching 1.375 times the running average, or a gap end).
// ============================================================================
//
//  channel   direction  transfer                      payload
//  in_ch     sink       one left/right pair           left_level, right_level,
//                                                     last_channel
//  out_ch    source     one result per frame          beat, in_gap, in_long_gap,
//                                                     gap_ended, frame_power,
//                                                     average_power, threshold
//  cfg       write      one register, no read-back    cfg_we, cfg_index, cfg_wdata
//
//  In the idle state a pair that is not the last of its frame is added to the
//  frame sum and in_ch stays ready. The last pair runs the check, history
//  write, divider start, bit-serial averaging division and beat decision; a gap
//  frame goes from the check straight to the result hand-off.
//  in_ch is not ready while a frame result is being computed, and that result
//  waits for the output register; a held result does not block new pairs.
//  No clearing pass after reset: the history holds only entries written since
//  the last restart.
//
module beat_peak_and_gap_detector_core #(
    parameter int HISTORY_DEPTH = bpgd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bpgd_in_if.sink                        in_ch,
    bpgd_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [bpgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpgd_pkg::CFG_W-1:0]     cfg_wdata
);

    bpgd_pkg::cmd_t    cmd;
    bpgd_pkg::status_t status;
    logic              in_ready;

    assign in_ch.ready = in_ready;

    bpgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.last_channel),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bpgd_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .left_level    (in_ch.left_level),
        .right_level   (in_ch.right_level),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .beat          (out_ch.beat),
        .in_gap        (out_ch.in_gap),
        .in_long_gap   (out_ch.in_long_gap),
        .gap_ended     (out_ch.gap_ended),
        .frame_power   (out_ch.frame_power),
        .average_power (out_ch.average_power),
        .threshold     (out_ch.threshold)
    );

endmodule

// ===== test/tb.sv =====
// ============================================================================
// tb: self-checking bench for beat_peak_and_gap_detector_core
// Streams frames of channel pairs into the block, predicts each frame result
// alongside it and checks every result transfer in order. A short directed
// run comes first, then random frames under several register settings and
// three stall patterns on the two channels.
// ============================================================================
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVEL_W        = bpgd_pkg::LEVEL_W;
    localparam int CFG_W          = bpgd_pkg::CFG_W;
    localparam int POWER_W        = bpgd_pkg::POWER_W;
    localparam int THR_W          = bpgd_pkg::THR_W;
    localparam int SILENT_W       = bpgd_pkg::SILENT_W;
    localparam int SINCE_W        = bpgd_pkg::SINCE_W;
    localparam int DEPTH          = bpgd_pkg::HISTORY_DEPTH_DEF;
    localparam int SLOT_W         = $clog2(DEPTH);
    localparam int TOTAL_W        = POWER_W + $clog2(DEPTH);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int REPORT_LIMIT   = 10;
    localparam int ITEMS_PER_SET  = 62;

    typedef struct packed {
        logic [LEVEL_W-1:0] left_level;
        logic [LEVEL_W-1:0] right_level;
        logic               last_channel;
    } pair_t;

    typedef struct packed {
        logic               beat;
        logic               in_gap;
        logic               in_long_gap;
        logic               gap_ended;
        logic [POWER_W-1:0] frame_power;
        logic [POWER_W-1:0] average_power;
        logic [THR_W-1:0]   threshold;
    } frame_result_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 src_valid = 1'b0;
    pair_t                src_pair  = '0;
    logic                 sink_ready = 1'b0;
    logic                 cfg_we    = 1'b0;
    bpgd_pkg::cfg_index_t cfg_index = bpgd_pkg::CFG_GAP_LENGTH;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    bpgd_in_if  in_ch ();
    bpgd_out_if out_ch ();

    assign in_ch.valid        = src_valid;
    assign in_ch.left_level   = src_pair.left_level;
    assign in_ch.right_level  = src_pair.right_level;
    assign in_ch.last_channel = src_pair.last_channel;
    assign out_ch.ready       = sink_ready;

    beat_peak_and_gap_detector_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Register shadows and detector state as the bench tracks it
    logic [CFG_W-1:0]    cur_gap_length      = bpgd_pkg::GAP_LENGTH_RST;
    logic [CFG_W-1:0]    cur_long_gap_length = bpgd_pkg::LONG_GAP_LENGTH_RST;
    logic [CFG_W-1:0]    cur_peak_spacing    = bpgd_pkg::PEAK_SPACING_RST;

    logic [POWER_W-1:0]  acc_frame_sum   = '0;
    logic                acc_nonzero     = 1'b0;
    logic [SILENT_W-1:0] silent_frames   = '0;
    logic                gap_active      = 1'b0;
    logic                long_gap_active = 1'b0;
    logic [POWER_W-1:0]  power_ring [DEPTH];
    logic [SLOT_W-1:0]   ring_slot       = SLOT_W'(DEPTH - 1);
    int                  ring_filled     = 0;
    logic [TOTAL_W-1:0]  ring_total      = '0;
    logic [SINCE_W-1:0]  frames_since_beat = '0;

    pair_t         pair_backlog [$];
    frame_result_t predicted_frames [$];
    int            queued_items   = 0;
    int            mismatch_count = 0;
    int            idle_cycles    = 0;
    int            send_idle_pct  = 0;
    int            recv_idle_pct  = 0;

    // Advance the detector by one accepted pair; a final pair yields a result
    task automatic predict_frame_result(input pair_t p);
        logic [POWER_W+1:0] sum_ext;
        logic               silent;
        logic               ended;
        logic               beat;
        logic [POWER_W-1:0] power;
        logic [TOTAL_W-1:0] quotient;
        logic [POWER_W-1:0] avg;
        logic [THR_W-1:0]   thr;
        frame_result_t      res;
        if (!p.last_channel)
        begin
            sum_ext = (POWER_W+2)'(acc_frame_sum) + (POWER_W+2)'(p.left_level)
                    + (POWER_W+2)'(p.right_level);
            acc_frame_sum = (sum_ext > (POWER_W+2)'(bpgd_pkg::POWER_MAX)) ?
                            bpgd_pkg::POWER_MAX : sum_ext[POWER_W-1:0];
            if ((p.left_level | p.right_level) != '0)
                acc_nonzero = 1'b1;
            return;
        end
        silent = !acc_nonzero && p.left_level == '0 && p.right_level == '0;
        power = acc_frame_sum;
        acc_frame_sum = '0;
        acc_nonzero = 1'b0;
        ended = 1'b0;
        beat = 1'b0;
        avg = '0;
        thr = '0;

        if (silent)
        begin
            if (silent_frames != bpgd_pkg::SILENT_MAX)
                silent_frames = silent_frames + 1'b1;
        end
        else
        begin
            silent_frames = '0;
            if (gap_active)
            begin
                gap_active = 1'b0;
                long_gap_active = 1'b0;
                ended = 1'b1;
            end
        end
        if (silent_frames > SILENT_W'(cur_gap_length))
            gap_active = 1'b1;
        if (silent_frames > SILENT_W'(cur_long_gap_length))
            long_gap_active = 1'b1;

        if (!gap_active)
        begin
            // first frame after a gap restarts the averaging
            if (ended)
            begin
                beat = 1'b1;
                frames_since_beat = cur_peak_spacing;
                ring_slot = SLOT_W'(DEPTH - 1);
                ring_filled = 0;
                ring_total = '0;
            end
            ring_slot = (ring_slot == SLOT_W'(DEPTH - 1)) ? '0 : ring_slot + 1'b1;
            if (ring_filled < DEPTH)
                ring_filled++;
            else
                ring_total = ring_total - TOTAL_W'(power_ring[ring_slot]);
            power_ring[ring_slot] = power;
            ring_total = ring_total + TOTAL_W'(power);

            quotient = ring_total / TOTAL_W'(ring_filled);
            avg = quotient[POWER_W-1:0];
            thr = THR_W'(avg) + THR_W'(avg >> 2) + THR_W'(avg >> 3);

            if (THR_W'(power) >= thr)
                beat = 1'b1;
            if (beat)
            begin
                if (frames_since_beat < cur_peak_spacing)
                    beat = 1'b0;
                else
                    frames_since_beat = '0;
            end
            if (frames_since_beat != bpgd_pkg::SINCE_MAX)
                frames_since_beat = frames_since_beat + 1'b1;
        end

        res.beat          = beat;
        res.in_gap        = gap_active;
        res.in_long_gap   = long_gap_active;
        res.gap_ended     = ended;
        res.frame_power   = power;
        res.average_power = avg;
        res.threshold     = thr;
        predicted_frames.push_back(res);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Input driver: hold valid until the transfer, then offer the next pair or idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
        end
        else
        begin
            if (src_valid && in_ch.ready)
                predict_frame_result(src_pair);
            if (!src_valid || in_ch.ready)
            begin
                if (pair_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    src_pair  <= pair_backlog.pop_front();
                    src_valid <= 1'b1;
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stall at random, compare each transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        frame_result_t got;
        frame_result_t want;
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
        end
        else
        begin
            sink_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (out_ch.valid && sink_ready)
            begin
                got.beat          = out_ch.beat;
                got.in_gap        = out_ch.in_gap;
                got.in_long_gap   = out_ch.in_long_gap;
                got.gap_ended     = out_ch.gap_ended;
                got.frame_power   = out_ch.frame_power;
                got.average_power = out_ch.average_power;
                got.threshold     = out_ch.threshold;
                if (predicted_frames.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result transfer with no frame pending: power %0d",
                                 $realtime, got.frame_power);
                end
                else
                begin
                    want = predicted_frames.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"%0t: frame result mismatch (expected/actual):",
                                      " beat %0d/%0d gap %0d/%0d long_gap %0d/%0d",
                                      " ended %0d/%0d power %0d/%0d avg %0d/%0d thr %0d/%0d"},
                                     $realtime, want.beat, got.beat,
                                     want.in_gap, got.in_gap,
                                     want.in_long_gap, got.in_long_gap,
                                     want.gap_ended, got.gap_ended,
                                     want.frame_power, got.frame_power,
                                     want.average_power, got.average_power,
                                     want.threshold, got.threshold);
                    end
                end
            end
        end
    end

    // Watchdog: abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && in_ch.ready) || (out_ch.valid && sink_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic push_pair(input logic [LEVEL_W-1:0] l, input logic [LEVEL_W-1:0] r,
                             input logic last);
        pair_t p;
        p.left_level   = l;
        p.right_level  = r;
        p.last_channel = last;
        pair_backlog.push_back(p);
        queued_items++;
    endtask

    // Frame of n pairs with levels up to scale, an occasional zero among them
    task automatic queue_frame(input int n_pairs, input int scale);
        logic [LEVEL_W-1:0] l;
        logic [LEVEL_W-1:0] r;
        for (int i = 0; i < n_pairs; i++)
        begin
            l = ($urandom_range(0, 7) == 0) ? '0 : LEVEL_W'($urandom_range(0, scale));
            r = ($urandom_range(0, 7) == 0) ? '0 : LEVEL_W'($urandom_range(0, scale));
            push_pair(l, r, i == n_pairs - 1);
        end
    endtask

    task automatic queue_random_frames(input int n_items);
        int first;
        int kind;
        int n_pairs;
        first = queued_items;
        while (queued_items - first < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 18)
            begin
                // silence run, long enough at times to open a gap and a long gap
                repeat ($urandom_range(1, 10)) queue_frame($urandom_range(1, 3), 0);
            end
            else if (kind < 26)
            begin
                // zero power, but the final pair keeps the frame out of silence
                n_pairs = $urandom_range(1, 4);
                repeat (n_pairs - 1) push_pair('0, '0, 1'b0);
                push_pair(LEVEL_W'($urandom_range(0, 65535)), LEVEL_W'($urandom_range(1, 65535)),
                          1'b1);
            end
            else
            begin
                queue_frame($urandom_range(1, 6), (1 << $urandom_range(2, 16)) - 1);
            end
        end
    endtask

    task automatic write_reg(input bpgd_pkg::cfg_index_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bpgd_pkg::CFG_GAP_LENGTH:      cur_gap_length = val;
            bpgd_pkg::CFG_LONG_GAP_LENGTH: cur_long_gap_length = val;
            bpgd_pkg::CFG_PEAK_SPACING:    cur_peak_spacing = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] gap_len,
                                  input logic [CFG_W-1:0] long_len,
                                  input logic [CFG_W-1:0] spacing);
        write_reg(bpgd_pkg::CFG_GAP_LENGTH, gap_len);
        write_reg(bpgd_pkg::CFG_LONG_GAP_LENGTH, long_len);
        write_reg(bpgd_pkg::CFG_PEAK_SPACING, spacing);
    endtask

    // Hold until every pair is sent and every result is in, then let the block settle
    task automatic drain();
        while (pair_backlog.size() != 0 || src_valid || predicted_frames.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [CFG_W-1:0] gap_len;
        logic [CFG_W-1:0] long_len;
        logic [CFG_W-1:0] spacing;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames: gap length zero, long gap length one and no beat spacing
        write_settings('0, 16'd1, '0);
        push_pair(16'hFFFF, 16'hFFFF, 1'b0);
        push_pair(16'hFFFF, 16'hFFFF, 1'b0);
        push_pair('0, '0, 1'b1);
        push_pair('0, 16'hFFFF, 1'b1);          // single pair, zero power, not silent
        push_pair(16'd1, '0, 1'b0);
        push_pair('0, '0, 1'b1);
        push_pair('0, '0, 1'b1);                // silent: opens a gap
        push_pair('0, '0, 1'b0);
        push_pair('0, '0, 1'b1);                // silent again: long gap
        push_pair('0, '0, 1'b0);
        push_pair(16'd5, '0, 1'b1);             // gap ends on a nonzero final pair
        push_pair(16'hFFFF, '0, 1'b0);
        push_pair('0, 16'hFFFF, 1'b0);
        push_pair(16'd1, 16'd1, 1'b1);
        push_pair('0, 16'd1, 1'b0);
        push_pair('0, '0, 1'b1);
        push_pair(16'hFFFF, 16'hFFFF, 1'b1);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 21 : 0;
            for (int k = 0; k < 4; k++)
            begin
                case (k)
                    0:
                    begin
                        gap_len  = CFG_W'($urandom_range(0, 4));
                        long_len = CFG_W'($urandom_range(0, 10));
                        spacing  = CFG_W'($urandom_range(0, 6));
                    end
                    1:
                    begin
                        gap_len  = '1;
                        long_len = '1;
                        spacing  = '1;
                    end
                    2:
                    begin
                        gap_len  = 16'd1;
                        long_len = 16'd1;
                        spacing  = 16'd1;
                    end
                    default:
                    begin
                        gap_len  = CFG_W'($urandom_range(0, 3));
                        long_len = CFG_W'($urandom_range(gap_len, 8));
                        spacing  = CFG_W'($urandom_range(0, 20));
                    end
                endcase
                write_settings(gap_len, long_len, spacing);
                queue_random_frames(ITEMS_PER_SET);
                if (phase == 2 && k == 3)
                begin
                    // loud frame long enough to saturate the frame sum
                    repeat (140) push_pair(LEVEL_W'($urandom_range(60000, 65535)),
                                           LEVEL_W'($urandom_range(60000, 65535)), 1'b0);
                    push_pair(LEVEL_W'($urandom_range(0, 65535)),
                              LEVEL_W'($urandom_range(0, 65535)), 1'b1);
                    queue_random_frames(8);
                end
                drain();
            end
        end

        if (mismatch_count == 0 && predicted_frames.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bpgd_pkg.sv
rtl/bpgd_in_if.sv
rtl/bpgd_out_if.sv
rtl/bpgd_div.sv
rtl/bpgd_ctrl.sv
rtl/bpgd_dp.sv
rtl/beat_peak_and_gap_detector_core.sv
test/tb.sv
